// ===== sv/twrt_pkg.sv =====
// Shared types for the tile window residency tracker.
package twrt_pkg;

    localparam int CoordW = 32;
    localparam int WidthW = 24;
    localparam int RadW   = 2;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CfgTileWidth    = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgWindowRadius = 1'b1;

    typedef struct packed {
        logic              vld;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] z;
    } tag_t;

    typedef struct packed {
        logic              evict;
        logic [CoordW-1:0] centre_x;
        logic [CoordW-1:0] centre_z;
        logic [RadW-1:0]   radius;
        logic [CoordW-1:0] cand_x;
        logic [CoordW-1:0] cand_z;
    } cell_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [CoordW-1:0] quotient;
    } div_status_t;

endpackage

// ===== sv/twrt_if.sv =====
// Handshake channels for viewer position items and load result items.
interface twrt_pos_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic signed [twrt_pkg::CoordW-1:0] pos_x;
    logic signed [twrt_pkg::CoordW-1:0] pos_z;

    modport source (output valid, operation, pos_x, pos_z, input ready);
    modport sink (input valid, operation, pos_x, pos_z, output ready);
endinterface

interface twrt_load_if;
    logic                        valid;
    logic                        ready;
    logic                        load_valid;
    logic signed [twrt_pkg::CoordW-1:0] tile_x;
    logic signed [twrt_pkg::CoordW-1:0] tile_z;
    logic                        last_result;

    modport source (output valid, load_valid, tile_x, tile_z, last_result, input ready);
    modport sink (input valid, load_valid, tile_x, tile_z, last_result, output ready);
endinterface

// ===== sv/twrt_div.sv =====
// Bit-serial signed floor divider of a 32-bit position by the unsigned tile width.
module twrt_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [twrt_pkg::CoordW-1:0]  dividend,
    input  logic [twrt_pkg::WidthW-1:0]  divisor,
    output twrt_pkg::div_status_t        status
);
    localparam int CW = twrt_pkg::CoordW;
    localparam int WW = twrt_pkg::WidthW;

    logic [WW-1:0]          rem_reg;
    logic [CW-1:0]          quo_reg;
    logic [WW-1:0]          dvs_reg;
    logic                   neg_reg;
    logic [$clog2(CW)-1:0]  cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [WW:0]            trial;
    logic [WW:0]            shifted;
    logic                   fits;
    logic [CW-1:0]          mag_q;

    assign shifted = {rem_reg, quo_reg[CW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign mag_q   = quo_reg;

    // Negative positions round toward minus infinity when a remainder is left.
    always_comb
    begin
        status.done = done_reg;
        if (neg_reg)
        begin
            status.quotient = CW'(0) - mag_q - CW'(rem_reg != '0);
        end
        else
        begin
            status.quotient = mag_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == ($clog2(CW))'(CW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(CW))'(CW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[CW-1];
            quo_reg <= dividend[CW-1] ? (CW'(0) - dividend) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= trial[WW-1:0];
                quo_reg <= {quo_reg[CW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WW-1:0];
                quo_reg <= {quo_reg[CW-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/twrt_cell.sv =====
// One tag cell of the residency chain: holds a tag, evicts it and passes it on.
module twrt_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  twrt_pkg::cell_ctrl_t   ctrl,
    input  twrt_pkg::tag_t         left,
    input  logic                   right_vld,
    output twrt_pkg::tag_t         tag,
    output logic                   hit
);
    localparam int CW = twrt_pkg::CoordW;

    logic          vld_reg;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] z_reg;
    logic [CW-1:0] dx;
    logic [CW-1:0] dz;
    logic [CW-1:0] mag_x;
    logic [CW-1:0] mag_z;
    logic          in_range;
    logic          vld_next;
    logic          take;

    assign dx       = x_reg - ctrl.centre_x;
    assign dz       = z_reg - ctrl.centre_z;
    assign mag_x    = dx[CW-1] ? (CW'(0) - dx) : dx;
    assign mag_z    = dz[CW-1] ? (CW'(0) - dz) : dz;
    assign in_range = (mag_x <= CW'(ctrl.radius)) && (mag_z <= CW'(ctrl.radius));

    assign tag.vld = vld_reg;
    assign tag.x   = x_reg;
    assign tag.z   = z_reg;
    assign hit     = vld_reg && (x_reg == ctrl.cand_x) && (z_reg == ctrl.cand_z);

    // Outside an eviction, a tag moves toward the far end whenever the next cell is empty.
    always_comb
    begin
        vld_next = vld_reg;
        take     = 1'b0;
        if (ctrl.evict)
        begin
            if (vld_reg && !in_range)
            begin
                vld_next = 1'b0;
            end
        end
        else if (vld_reg)
        begin
            if (!right_vld)
            begin
                vld_next = 1'b0;
            end
        end
        else if (left.vld)
        begin
            vld_next = 1'b1;
            take     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= left.x;
            z_reg <= left.z;
        end
    end

endmodule

// ===== sv/tile_window_residency_tracker.sv =====
// Top level of the tile window residency tracker.
//
//  channel  direction  payload                                   accepted when
//  pos      in         operation, pos_x, pos_z                   valid && ready
//  load     out        load_valid, tile_x, tile_z, last_result   valid && ready
//  cfg      in         cfg_index, cfg_data                       cfg_we
//
// One item at a time: the divider runs its 32 steps and then shows the finish, an eviction
// step follows when the centre moves, and the tag chain is given time to settle. Then each
// window tile is checked in turn and each loaded tile is followed by a gap state; with
// operation low the scan ends at the first load. Each result waits on the receiver; the
// final result ends the item. A tag moves one cell per cycle into an empty next cell.
// Reset empties the tag chain at once. A stalled result holds the scan at the next load.
module tile_window_residency_tracker
#(
    parameter int MAX_RADIUS = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [twrt_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [twrt_pkg::WidthW-1:0]        cfg_data,
    twrt_pos_if.sink                           pos,
    twrt_load_if.source                        load
);
    localparam int CW       = twrt_pkg::CoordW;
    localparam int RW       = twrt_pkg::RadW;
    localparam int TagDepth = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SettleCycles = TagDepth + 2;
    localparam int SetW     = $clog2(SettleCycles + 1);
    localparam logic [RW-1:0] MaxRad = RW'(MAX_RADIUS);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_EVICT, S_SETTLE, S_CHECK, S_GAP, S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [twrt_pkg::WidthW-1:0] tile_width_reg;
    logic [RW-1:0]            window_radius_reg;
    logic                     op_reg;
    logic [RW-1:0]            r_reg;
    logic [CW-1:0]            centre_x_reg;
    logic [CW-1:0]            centre_z_reg;
    logic                     centre_known_reg;
    logic [SetW-1:0]          cnt_reg;
    logic signed [2:0]        dx_reg;
    logic signed [2:0]        dz_reg;
    logic [CW-1:0]            cand_x_reg;
    logic [CW-1:0]            cand_z_reg;
    logic                     pend_vld_reg;
    logic [CW-1:0]            pend_x_reg;
    logic [CW-1:0]            pend_z_reg;
    logic                     out_vld_reg;
    logic                     out_load_reg;
    logic [CW-1:0]            out_x_reg;
    logic [CW-1:0]            out_z_reg;
    logic                     out_last_reg;

    logic                     accept;
    logic                     div_start;
    logic [RW-1:0]            r_eff;
    twrt_pkg::div_status_t    div_x;
    twrt_pkg::div_status_t    div_z;
    twrt_pkg::cell_ctrl_t     ctrl;
    twrt_pkg::tag_t           ins;
    twrt_pkg::tag_t           tags [TagDepth];
    logic [TagDepth-1:0]      hits;
    logic                     any_hit;
    logic                     free0;
    logic                     do_ins;
    logic signed [2:0]        r_s;
    logic signed [2:0]        neg_r;
    logic [CW-1:0]            neg_r_ext;

    assign r_eff     = (window_radius_reg < MaxRad) ? window_radius_reg : MaxRad;
    assign pos.ready = (state_reg == S_IDLE);
    assign accept    = pos.valid && pos.ready;
    assign div_start = accept && (tile_width_reg != '0);

    assign load.valid       = out_vld_reg;
    assign load.load_valid  = out_load_reg;
    assign load.tile_x      = out_x_reg;
    assign load.tile_z      = out_z_reg;
    assign load.last_result = out_last_reg;

    assign r_s       = $signed({1'b0, r_reg});
    assign neg_r     = -r_s;
    assign neg_r_ext = {{(CW-3){neg_r[2]}}, neg_r};

    assign any_hit = |hits;
    assign free0   = !tags[0].vld;
    assign do_ins  = (state_reg == S_CHECK) && !any_hit && free0
                     && !(pend_vld_reg && out_vld_reg);

    always_comb
    begin
        ctrl.evict    = (state_reg == S_EVICT);
        ctrl.centre_x = centre_x_reg;
        ctrl.centre_z = centre_z_reg;
        ctrl.radius   = r_reg;
        ctrl.cand_x   = cand_x_reg;
        ctrl.cand_z   = cand_z_reg;
        ins.vld       = do_ins;
        ins.x         = cand_x_reg;
        ins.z         = cand_z_reg;
    end

    twrt_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pos.pos_x),
        .divisor  (tile_width_reg),
        .status   (div_x)
    );

    twrt_div u_div_z
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pos.pos_z),
        .divisor  (tile_width_reg),
        .status   (div_z)
    );

    for (genvar i = 0; i < TagDepth; i++)
    begin : g_cell
        twrt_pkg::tag_t left;
        logic           right_vld;

        if (i == 0)
        begin : g_first
            assign left = ins;
        end
        else
        begin : g_mid
            assign left = tags[i-1];
        end

        if (i == TagDepth - 1)
        begin : g_last
            assign right_vld = 1'b1;
        end
        else
        begin : g_inner
            assign right_vld = tags[i+1].vld;
        end

        twrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left),
            .right_vld (right_vld),
            .tag       (tags[i]),
            .hit       (hits[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg    <= '0;
            window_radius_reg <= RW'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                twrt_pkg::CfgTileWidth:    tile_width_reg    <= cfg_data;
                twrt_pkg::CfgWindowRadius: window_radius_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            centre_known_reg <= 1'b0;
            centre_x_reg     <= '0;
            centre_z_reg     <= '0;
            pend_vld_reg     <= 1'b0;
            out_vld_reg      <= 1'b0;
            cnt_reg          <= '0;
            op_reg           <= 1'b0;
            r_reg            <= '0;
            dx_reg           <= '0;
            dz_reg           <= '0;
            cand_x_reg       <= '0;
            cand_z_reg       <= '0;
            pend_x_reg       <= '0;
            pend_z_reg       <= '0;
            out_load_reg     <= 1'b0;
            out_x_reg        <= '0;
            out_z_reg        <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && load.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (div_start)
                    begin
                        op_reg    <= pos.operation;
                        r_reg     <= r_eff;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    cnt_reg <= '0;
                    if (div_x.done)
                    begin
                        if (!centre_known_reg || (div_x.quotient != centre_x_reg)
                            || (div_z.quotient != centre_z_reg))
                        begin
                            centre_x_reg     <= div_x.quotient;
                            centre_z_reg     <= div_z.quotient;
                            centre_known_reg <= 1'b1;
                            state_reg        <= S_EVICT;
                        end
                        else
                        begin
                            state_reg <= S_SETTLE;
                        end
                    end
                end

                S_EVICT:
                begin
                    state_reg <= S_SETTLE;
                end

                S_SETTLE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SetW'(SettleCycles - 1))
                    begin
                        dx_reg       <= neg_r;
                        dz_reg       <= neg_r;
                        cand_x_reg   <= centre_x_reg + neg_r_ext;
                        cand_z_reg   <= centre_z_reg + neg_r_ext;
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_CHECK;
                    end
                end

                S_CHECK, S_GAP:
                begin
                    if (state_reg == S_CHECK && do_ins)
                    begin
                        // The previous load goes out now that a later one exists.
                        if (pend_vld_reg)
                        begin
                            out_vld_reg  <= 1'b1;
                            out_load_reg <= 1'b1;
                            out_x_reg    <= pend_x_reg;
                            out_z_reg    <= pend_z_reg;
                            out_last_reg <= 1'b0;
                        end
                        pend_vld_reg <= 1'b1;
                        pend_x_reg   <= cand_x_reg;
                        pend_z_reg   <= cand_z_reg;
                        state_reg    <= op_reg ? S_GAP : S_FINISH;
                    end
                    else if (state_reg == S_GAP || any_hit || !free0)
                    begin
                        if (dx_reg == r_s)
                        begin
                            if (dz_reg == r_s)
                            begin
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                dz_reg     <= dz_reg + 3'sd1;
                                dx_reg     <= neg_r;
                                cand_x_reg <= centre_x_reg + neg_r_ext;
                                cand_z_reg <= cand_z_reg + CW'(1);
                                state_reg  <= S_CHECK;
                            end
                        end
                        else
                        begin
                            dx_reg     <= dx_reg + 3'sd1;
                            cand_x_reg <= cand_x_reg + CW'(1);
                            state_reg  <= S_CHECK;
                        end
                    end
                end

                S_FINISH:
                begin
                    if (!out_vld_reg)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_load_reg <= pend_vld_reg;
                        out_x_reg    <= pend_vld_reg ? pend_x_reg : '0;
                        out_z_reg    <= pend_vld_reg ? pend_z_reg : '0;
                        out_last_reg <= 1'b1;
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/twrt_checker.sv =====
// Port-level assertions for the tile window residency tracker, with its bind.
module twrt_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          load_valid,
    input logic [twrt_pkg::CoordW-1:0]   tile_x,
    input logic [twrt_pkg::CoordW-1:0]   tile_z,
    input logic                          last_result
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(tile_x) && $stable(tile_z)
            && $stable(load_valid) && $stable(last_result))
        else $error("result changed while stalled");

    // A result with nothing to load is the only and final one, with zero coordinates.
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !load_valid |-> last_result && (tile_x == '0) && (tile_z == '0))
        else $error("empty result is malformed");

    // While a non-final result is shown the item is still being worked on.
    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
        else $error("new item taken before the last result");

endmodule

bind tile_window_residency_tracker twrt_checker u_twrt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pos.ready),
    .out_valid   (load.valid),
    .out_ready   (load.ready),
    .load_valid  (load.load_valid),
    .tile_x      (load.tile_x),
    .tile_z      (load.tile_z),
    .last_result (load.last_result)
);

// ===== sim/tb_tile_window_residency_tracker.sv =====
// Testbench for the tile window residency tracker: random and directed positions, self-checked.
module tb_tile_window_residency_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CoordW  = twrt_pkg::CoordW;
    localparam int WidthW  = twrt_pkg::WidthW;
    localparam int RadW    = twrt_pkg::RadW;
    localparam int CfgIdxW = twrt_pkg::CfgIdxW;
    localparam int MaxRad = 2;
    localparam int TagDepth = (2 * MaxRad + 1) * (2 * MaxRad + 1);

    typedef struct {
        logic              load_valid;
        logic [CoordW-1:0] tile_x;
        logic [CoordW-1:0] tile_z;
        logic              last_result;
    } load_t;

    // Predicts the load list of each accepted position and checks results in order.
    class load_scoreboard;
        logic [WidthW-1:0] tile_width;
        logic [RadW-1:0]   radius;
        logic              resident[TagDepth];
        logic [CoordW-1:0] res_x[TagDepth];
        logic [CoordW-1:0] res_z[TagDepth];
        logic [CoordW-1:0] cen_x, cen_z;
        logic              cen_known;
        load_t             pending_loads[$];
        int                errors;
        int                checked;

        function new();
            tile_width = '0;
            radius = 2'd2;
            foreach (resident[i]) resident[i] = 1'b0;
            cen_x = '0;
            cen_z = '0;
            cen_known = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [CoordW-1:0] tile_of(logic signed [CoordW-1:0] p);
            longint q;
            longint pp;
            pp = p;
            q = pp / longint'(tile_width);
            if ((pp % longint'(tile_width)) != 0 && pp < 0) q = q - 1;
            return q[CoordW-1:0];
        endfunction

        function bit near(logic [CoordW-1:0] a, logic [CoordW-1:0] c, int r);
            logic [CoordW-1:0] d;
            logic [CoordW-1:0] mag;
            d = a - c;
            mag = d[CoordW-1] ? -d : d;
            return mag <= r;
        endfunction

        function void note_position(logic op, logic signed [CoordW-1:0] px,
                                    logic signed [CoordW-1:0] pz);
            logic [CoordW-1:0] cx, cz, tx, tz;
            int r, n;
            bit hit, stop;
            load_t e;
            if (tile_width == 0) return;
            r = (radius < MaxRad) ? radius : MaxRad;
            cx = tile_of(px);
            cz = tile_of(pz);
            if (!cen_known || cx != cen_x || cz != cen_z) begin
                cen_x = cx;
                cen_z = cz;
                cen_known = 1'b1;
                for (int i = 0; i < TagDepth; i++)
                    if (resident[i] && (!near(res_x[i], cx, r) || !near(res_z[i], cz, r)))
                        resident[i] = 1'b0;
            end
            n = 0;
            stop = 0;
            for (int dz = -r; dz <= r && !stop; dz++) begin
                for (int dx = -r; dx <= r && !stop; dx++) begin
                    tx = cen_x + dx;
                    tz = cen_z + dz;
                    hit = 0;
                    for (int i = 0; i < TagDepth; i++)
                        if (resident[i] && res_x[i] == tx && res_z[i] == tz) hit = 1;
                    if (!hit) begin
                        for (int i = 0; i < TagDepth; i++) begin
                            if (!hit && !resident[i]) begin
                                resident[i] = 1'b1;
                                res_x[i] = tx;
                                res_z[i] = tz;
                                hit = 1;
                                e.load_valid = 1'b1;
                                e.tile_x = tx;
                                e.tile_z = tz;
                                e.last_result = 1'b0;
                                pending_loads.push_back(e);
                                n++;
                                if (!op) stop = 1;
                            end
                        end
                    end
                end
            end
            if (n == 0) begin
                e.load_valid = 1'b0;
                e.tile_x = '0;
                e.tile_z = '0;
                e.last_result = 1'b0;
                pending_loads.push_back(e);
            end
            pending_loads[$].last_result = 1'b1;
        endfunction

        function void check_load(load_t got);
            load_t e;
            checked++;
            if (pending_loads.size() == 0) begin
                $error("unexpected load result x=%0d z=%0d", $signed(got.tile_x),
                       $signed(got.tile_z));
                errors++;
                return;
            end
            e = pending_loads.pop_front();
            if (got.load_valid !== e.load_valid) begin
                $error("load_valid expected %0b actual %0b", e.load_valid, got.load_valid);
                errors++;
            end
            if (got.tile_x !== e.tile_x) begin
                $error("tile_x expected %0d actual %0d", $signed(e.tile_x), $signed(got.tile_x));
                errors++;
            end
            if (got.tile_z !== e.tile_z) begin
                $error("tile_z expected %0d actual %0d", $signed(e.tile_z), $signed(got.tile_z));
                errors++;
            end
            if (got.last_result !== e.last_result) begin
                $error("last_result expected %0b actual %0b", e.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [WidthW-1:0] cfg_data;

    twrt_pos_if pos ();
    twrt_load_if load ();

    tile_window_residency_tracker dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pos(pos.sink), .load(load.source)
    );

    load_scoreboard sb;
    int  hold_off;
    int  sent;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WidthW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == twrt_pkg::CfgTileWidth) sb.tile_width = val;
        else sb.radius = val[RadW-1:0];
    endtask

    // Releases the input, then waits until every expected result has come, plus a pause.
    task automatic drain();
        int guard;
        guard = 0;
        pos.valid <= 1'b0;
        while (sb.pending_loads.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    // The input stays offered after acceptance until the next item or an idle gap replaces it.
    task automatic send_position(logic op, logic [CoordW-1:0] px, logic [CoordW-1:0] pz,
                                 int gap);
        if (gap > 0)
        begin
            pos.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pos.valid <= 1'b1;
        pos.operation <= op;
        pos.pos_x <= px;
        pos.pos_z <= pz;
        do @(posedge clk); while (!pos.ready);
        sb.note_position(op, px, pz);
        sent++;
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [CoordW-1:0] rand_pos(logic [WidthW-1:0] w, logic [CoordW-1:0] base);
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return base + $urandom_range(0, 3 * w) - w;
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off when requested.
    initial
    begin
        load_t got;
        int wait_cycles;
        load.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                load.ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (wait_cycles > 0)
            begin
                load.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            load.ready <= 1'b1;
            do @(posedge clk); while (!load.valid);
            got.load_valid = load.load_valid;
            got.tile_x = load.tile_x;
            got.tile_z = load.tile_z;
            got.last_result = load.last_result;
            sb.check_load(got);
        end
    end

    initial
    begin
        logic [CoordW-1:0] bx, bz;
        logic [WidthW-1:0] w;
        sb = new();
        hold_off = 0;
        sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = twrt_pkg::CfgTileWidth;
        cfg_data = '0;
        pos.valid = 1'b0;
        pos.operation = 1'b0;
        pos.pos_x = '0;
        pos.pos_z = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Zero tile width: items are ignored.
        send_position(1'b1, 32'd1000, 32'd1000, 0);
        send_position(1'b0, 32'h8000_0000, 32'h7fff_ffff, 2);
        drain();
        write_reg(twrt_pkg::CfgTileWidth, 24'd256);
        write_reg(twrt_pkg::CfgWindowRadius, 24'd3);
        send_position(1'b0, 32'd0, 32'd0, 0);
        send_position(1'b1, 32'd0, 32'd0, 0);
        send_position(1'b1, 32'd10, 32'd20, 0);
        send_position(1'b0, -32'sd1, -32'sd257, 1);
        send_position(1'b1, -32'sd1, -32'sd257, 1);
        send_position(1'b1, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_position(1'b1, 32'h8000_0000, 32'h7fff_ffff, 3);
        drain();
        write_reg(twrt_pkg::CfgTileWidth, 24'd1);
        write_reg(twrt_pkg::CfgWindowRadius, 24'd0);
        send_position(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_position(1'b1, 32'h8000_0000, 32'h8000_0000, 0);
        send_position(1'b0, 32'h7fff_ffff, 32'h8000_0000, 0);
        drain();
        write_reg(twrt_pkg::CfgTileWidth, 24'hff_ffff);
        write_reg(twrt_pkg::CfgWindowRadius, 24'd1);
        send_position(1'b1, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_position(1'b1, -32'sd1, 32'd0, 0);
        send_position(1'b0, 32'hffff_fffe, 32'h0100_0000, 0);
        drain();
        write_reg(twrt_pkg::CfgWindowRadius, 24'd2);
        write_reg(twrt_pkg::CfgTileWidth, 24'd7);
        send_position(1'b1, -32'sd7, -32'sd8, 0);
        send_position(1'b1, -32'sd6, -32'sd14, 0);

        // Long receiver hold-off while the sender keeps offering items.
        hold_off = 600;
        for (int i = 0; i < 6; i++)
            send_position(1'($urandom_range(0, 1)), $urandom(), $urandom(), 0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: w = WidthW'($urandom_range(1, 1024));
                1: w = WidthW'(24'hff_ffff - $urandom_range(0, 3));
                2: w = 24'd1;
                default: w = WidthW'($urandom());
            endcase
            write_reg(twrt_pkg::CfgTileWidth, w);
            write_reg(twrt_pkg::CfgWindowRadius, WidthW'($urandom_range(0, 3)));
            bx = $urandom();
            bz = $urandom();
            for (int i = 0; i < 36; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    bx = $urandom();
                    bz = $urandom();
                end
                send_position(1'($urandom_range(0, 1)), rand_pos(w, bx), rand_pos(w, bz),
                              draw_gap());
            end
            // Sender pauses until every expected result has come.
            drain();
        end
        write_reg(twrt_pkg::CfgTileWidth, 24'd0);
        send_position(1'b1, $urandom(), $urandom(), 0);
        drain();
        if (sb.pending_loads.size() != 0) sb.errors++;
        $display("Sent %0d position items, checked %0d load results,", sent, sb.checked);
        $display("over tile widths from 1 to the maximum and radii 0 to 3.");
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
